[sv/stree_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment tree range sum: shared package
// Field widths, tree geometry, command codes and the types that pass between
// the front end, the command queue and the tree sequencer.
// ----------------------------------------------------------------------------
package stree_pkg;

   localparam int POS_W      = 11;
   localparam int VALUE_W    = 64;
   localparam int LEAVES     = 1024;
   localparam int NODES      = 2 * LEAVES;
   localparam int IDX_W      = $clog2(NODES);
   localparam int NODE_W     = IDX_W + 1;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [POS_W-1:0] LEAVES_CAP =
      (LEAVES > (2 ** POS_W) - 1) ? POS_W'((2 ** POS_W) - 1) : POS_W'(LEAVES);
   localparam logic [POS_W-1:0] LEAVES_IN_USE_RESET = POS_W'(1024);
   localparam logic [IDX_W-1:0] LAST_NODE = IDX_W'(NODES - 1);

   localparam logic CMD_SET      = 1'b0;
   localparam logic CMD_QUERY    = 1'b1;
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   typedef enum logic [1:0] {
      OP_SET,
      OP_QUERY,
      OP_REJECT
   } op_type;

   typedef struct packed {
      op_type                    op;
      logic [IDX_W-1:0]          lo_index;
      logic [IDX_W-1:0]          hi_index;
      logic signed [VALUE_W-1:0] value;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_RD,
      ST_SET_WR,
      ST_Q_CHK,
      ST_Q_LO,
      ST_Q_HI_CHK,
      ST_Q_HI,
      ST_DONE
   } state_type;

endpackage

[sv/stree_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment tree range sum: channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface stree_req_if;
   import stree_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      command;
   logic [POS_W-1:0]          first_position;
   logic [POS_W-1:0]          last_position;
   logic signed [VALUE_W-1:0] new_value;

   modport source (output valid, command, first_position, last_position, new_value,
                   input ready);
   modport sink   (input valid, command, first_position, last_position, new_value,
                   output ready);
endinterface

interface stree_rsp_if;
   import stree_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] range_sum;
   logic                      status;

   modport source (output valid, range_sum, status, input ready);
   modport sink   (input valid, range_sum, status, output ready);
endinterface

[sv/stree_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stree_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

[sv/stree_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment tree range sum: front end
// Holds the leaf limit register, checks positions and turns each request into
// a queue entry with node indices.
// ----------------------------------------------------------------------------
module stree_front (
   input  logic                        clock,
   input  logic                        reset,
   stree_req_if.sink                   req,
   input  logic                        csr_wr_en,
   input  logic [stree_pkg::POS_W-1:0] csr_wr_data,
   input  logic                        clearing,
   input  logic                        queue_ready,
   output logic                        push,
   output stree_pkg::entry_type        push_entry
);
   import stree_pkg::*;

   logic [POS_W-1:0] leaves_in_use_ff;
   logic [POS_W-1:0] leaves_in_use_in;
   logic [POS_W-1:0] limit;
   logic             first_ok;
   logic             last_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         leaves_in_use_ff <= LEAVES_IN_USE_RESET;
      end else begin
         leaves_in_use_ff <= leaves_in_use_in;
      end
   end

   assign leaves_in_use_in = csr_wr_en ? csr_wr_data : leaves_in_use_ff;
   assign limit    = (leaves_in_use_ff > LEAVES_CAP) ? LEAVES_CAP : leaves_in_use_ff;
   assign first_ok = (req.first_position != '0) && (req.first_position <= limit);
   assign last_ok  = (req.last_position != '0) && (req.last_position <= limit);

   assign req.ready = queue_ready && !clearing;
   assign push      = req.valid && req.ready;

   always_comb begin
      push_entry.lo_index = IDX_W'(LEAVES - 1) + IDX_W'(req.first_position);
      push_entry.hi_index = IDX_W'(LEAVES - 1) + IDX_W'(req.last_position);
      push_entry.value    = req.new_value;
      case (req.command)
         CMD_SET: begin
            push_entry.op = first_ok ? OP_SET : OP_REJECT;
         end
         CMD_QUERY: begin
            push_entry.op = (first_ok && last_ok) ? OP_QUERY : OP_REJECT;
         end
         default: begin
            push_entry.op = OP_REJECT;
         end
      endcase
   end
endmodule

[sv/stree_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment tree range sum: command queue
// A short first-in first-out queue between the front end and the sequencer.
// ----------------------------------------------------------------------------
module stree_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  stree_pkg::entry_type push_entry,
   output logic                 push_ready,
   input  logic                 pop,
   output logic                 pop_valid,
   output stree_pkg::entry_type pop_entry
);
   import stree_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   entry_type        slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end
endmodule

[sv/stree_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment tree range sum: tree sequencer
// Clears the node store after reset, then walks the tree for each queued set
// or query, answers a rejected command without a walk, and registers one
// response per request.
module stree_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 entry_valid,
   input  stree_pkg::entry_type entry,
   output logic                 pop,
   output logic                 clearing,
   stree_rsp_if.source          rsp
);
   import stree_pkg::*;

   state_type                 state_ff, state_in;
   logic [NODE_W-1:0]         lo_ff, lo_in;
   logic [NODE_W-1:0]         hi_ff, hi_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic signed [VALUE_W-1:0] delta_ff, delta_in;
   logic signed [VALUE_W-1:0] acc_ff, acc_in;
   logic                      first_ff, first_in;
   logic [IDX_W-1:0]          clr_ff, clr_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                      rsp_status_ff, rsp_status_in;

   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   logic [VALUE_W-1:0]        wr_data;
   logic [IDX_W-1:0]          rd_addr;
   logic [VALUE_W-1:0]        rd_data;
   logic                      out_free;
   logic [NODE_W-1:0]         lo_up;

   stree_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (NODES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign clearing   = (state_ff == ST_CLEAR);
   assign rsp.valid  = rsp_valid_ff;
   assign rsp.range_sum = rsp_sum_ff;
   assign rsp.status = rsp_status_ff;
   assign lo_up      = lo_ff >> 1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      value_ff      <= value_in;
      delta_ff      <= delta_in;
      acc_ff        <= acc_in;
      first_ff      <= first_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      value_in      = value_ff;
      delta_in      = delta_ff;
      acc_in        = acc_ff;
      first_in      = first_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = lo_ff[IDX_W-1:0];
      wr_data       = '0;
      rd_addr       = lo_ff[IDX_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (entry_valid && out_free) begin
               pop      = 1'b1;
               lo_in    = {1'b0, entry.lo_index};
               hi_in    = {1'b0, entry.hi_index};
               value_in = entry.value;
               acc_in   = '0;
               first_in = 1'b1;
               case (entry.op)
                  OP_SET: begin
                     state_in = ST_SET_RD;
                  end
                  OP_QUERY: begin
                     state_in = ST_Q_CHK;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_sum_in    = '0;
                     rsp_status_in = STATUS_RANGE;
                  end
               endcase
            end
         end
         ST_SET_RD: begin
            state_in = ST_SET_WR;
         end
         ST_SET_WR: begin
            wr_en    = 1'b1;
            first_in = 1'b0;
            if (first_ff) begin
               wr_data  = value_ff;
               delta_in = value_ff - $signed(rd_data);
            end else begin
               wr_data  = rd_data + delta_ff;
            end
            lo_in    = lo_up;
            state_in = (lo_up == '0) ? ST_DONE : ST_SET_RD;
         end
         ST_Q_CHK: begin
            if (lo_ff > hi_ff) begin
               state_in = ST_DONE;
            end else if (lo_ff[0]) begin
               state_in = ST_Q_LO;
            end else begin
               state_in = ST_Q_HI_CHK;
            end
         end
         ST_Q_LO: begin
            acc_in   = acc_ff + $signed(rd_data);
            lo_in    = lo_ff + 1'b1;
            state_in = ST_Q_HI_CHK;
         end
         ST_Q_HI_CHK: begin
            rd_addr = hi_ff[IDX_W-1:0];
            if ((lo_ff <= hi_ff) && !hi_ff[0]) begin
               state_in = ST_Q_HI;
            end else begin
               lo_in    = lo_up;
               hi_in    = hi_ff >> 1;
               state_in = ST_Q_CHK;
            end
         end
         ST_Q_HI: begin
            acc_in   = acc_ff + $signed(rd_data);
            hi_in    = (hi_ff - 1'b1) >> 1;
            lo_in    = lo_up;
            state_in = ST_Q_CHK;
         end
         ST_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_sum_in    = acc_ff;
            rsp_status_in = STATUS_DONE;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

[sv/segment_tree_range_sum_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment tree range sum core
// Point update and inclusive range sum over 1024 signed 64-bit leaves.
// ----------------------------------------------------------------------------
// Requests arrive on req: a set writes new_value to leaf first_position, a
// query sums the leaves from first_position to last_position. Each request
// gives exactly one response on rsp with range_sum and status; status is set
// when a position that it uses is zero or above the leaf limit, and then nothing changes.
// The leaf limit is written through csr_wr_en and csr_wr_data; the user must
// write it only while idle, as the block itself does not enforce that.
// After reset the node store is cleared, one node a cycle, all 2048 nodes, and
// req.ready stays low until that pass ends. A set reads and rewrites each
// node on the path from its leaf up to the root; a query climbs the tree from
// both ends of the range and adds the boundary nodes, and an empty range gives
// a zero sum. All node reads use the single read port of the node memory.
// A two-entry queue sits between the request checker and the tree walker,
// so requests are still taken while a response waits on a stalled receiver.
// ----------------------------------------------------------------------------
module segment_tree_range_sum_core (
   input  logic                        clock,
   input  logic                        reset,
   stree_req_if.sink                   req,
   stree_rsp_if.source                 rsp,
   input  logic                        csr_wr_en,
   input  logic [stree_pkg::POS_W-1:0] csr_wr_data
);
   import stree_pkg::*;

   logic      push;
   entry_type push_entry;
   logic      queue_ready;
   logic      pop;
   logic      pop_valid;
   entry_type pop_entry;
   logic      clearing;

   stree_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .clearing    (clearing),
      .queue_ready (queue_ready),
      .push        (push),
      .push_entry  (push_entry)
   );

   stree_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (queue_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry)
   );

   stree_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (pop_valid),
      .entry       (pop_entry),
      .pop         (pop),
      .clearing    (clearing),
      .rsp         (rsp)
   );
endmodule
